@@ rtl/zbpa_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, types and helpers for the zoned bitmap page allocator.
// No dependencies.
package zbpa_pkg;

    localparam int ZONE_PAGES = 1024;
    localparam int MAX_RUN    = 16;
    localparam int ZONES      = 2;

    // Field widths fixed by the interface
    localparam int PFN_W     = 20;
    localparam int CNT_W     = 11;
    localparam int RUN_W     = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 20;

    // Bitmap organization: 16 pages per memory word, a run spans at most two words
    localparam int WORD_W   = 16;
    localparam int OFF_W    = $clog2(WORD_W);
    localparam int DEPTH    = (ZONES * ZONE_PAGES + WORD_W - 1) / WORD_W;
    localparam int WA_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BIT_W    = WA_W + OFF_W;
    localparam int ZB       = $clog2(ZONE_PAGES);
    localparam int SIZE_MAX = (ZONE_PAGES < 2047) ? ZONE_PAGES : 2047;
    localparam int HINT_W   = $clog2(SIZE_MAX + 2);
    localparam int CMP_W    = CNT_W + 1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOFIT    = 2'd1,
        ST_OUTSIDE  = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    localparam logic FN_ALLOC = 1'b0;
    localparam logic FN_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_A_BASE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_A_PAGES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B_BASE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_B_PAGES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RSV     = 3'd4;

    // Effective zone size: page register saturated at the zone capacity
    function automatic logic [CNT_W-1:0] zone_size(input logic [CNT_W-1:0] pages);
        logic [CNT_W-1:0] s;
        if (int'(pages) > ZONE_PAGES) s = CNT_W'(ZONE_PAGES);
        else s = pages;
        return s;
    endfunction

endpackage

@@ rtl/zbpa_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module zbpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ rtl/zoned_bitmap_page_allocator.sv @@
`timescale 1ns / 1ps
// Zoned bitmap page-frame allocator, top level.
// Depends on zbpa_pkg and zbpa_ram (used-bit bitmap storage).
//
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: page_number, page_count; tuser: func
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: result_page, status
// cfg       in   i_cfg_valid/o_cfg_ready      i_cfg_index, i_cfg_data
//
// One request at a time. Allocate: decode, two bitmap word reads, check and two writes;
// a zero-length run or a refusal at decode is answered straight from decode, and a busy
// hint run is refused at the check.
// Free: one read-modify-write of a bitmap word per page.
// Reset clears the per-word valid bits, so the bitmap reads as all free at once.
// A result waiting on m_axis does not block the next request; the block stalls only
// when a new result is ready and the previous one has not been taken.
module zoned_bitmap_page_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [31:0]                   s_axis_tdata,  // [19:0] page_number, [24:20] page_count
    input  logic [0:0]                    s_axis_tuser,  // [0] func
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [23:0]                   m_axis_tdata,  // [19:0] result_page, [21:20] status
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [zbpa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [zbpa_pkg::CFG_W-1:0]    i_cfg_data
);
    import zbpa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_ARD0, S_ARD1, S_ACHK, S_AWR1, S_FRD, S_FWR, S_RESP
    } t_state;

    t_state r_state;

    // configuration and zone state
    logic [PFN_W-1:0]  r_a_base, r_b_base;
    logic [CNT_W-1:0]  r_a_pages, r_b_pages;
    logic [1:0]        r_rsv;
    logic [CNT_W-1:0]  r_free_a, r_free_b;
    logic [HINT_W-1:0] r_hint_a, r_hint_b;

    // request and working registers
    logic              r_func;
    logic [PFN_W-1:0]  r_pnum;
    logic [RUN_W-1:0]  r_cnt;
    logic              r_zone;
    logic [WA_W-1:0]   r_waddr;
    logic [OFF_W-1:0]  r_off;
    logic [WORD_W-1:0] r_word0, r_word1;
    logic [PFN_W-1:0]  r_cur;
    logic [RUN_W-1:0]  r_k;
    logic [PFN_W-1:0]  r_page;
    t_status           r_status;

    // output register
    logic              r_m_valid;
    logic [PFN_W-1:0]  r_m_page;
    t_status           r_m_status;

    // bitmap storage
    logic [DEPTH-1:0]  r_vld;
    logic              r_rd_vld;
    logic              ram_we;
    logic [WA_W-1:0]   ram_waddr, ram_raddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata, rd_word;

    logic [CNT_W-1:0]  size_a, size_b;
    assign size_a = zone_size(r_a_pages);
    assign size_b = zone_size(r_b_pages);

    // ---------------- allocate decode ----------------
    logic              a_ok, b_ok, pick;
    logic [HINT_W-1:0] al_h;
    logic [CNT_W-1:0]  al_size;
    logic              al_fit;
    logic [BIT_W-1:0]  al_idx;

    always_comb begin
        a_ok    = !r_rsv[0] && (r_free_a > CNT_W'(r_cnt));
        b_ok    = (ZONES > 1) && !r_rsv[1] && (r_free_b > CNT_W'(r_cnt));
        pick    = !a_ok;
        al_h    = pick ? r_hint_b : r_hint_a;
        al_size = pick ? size_b : size_a;
        al_fit  = (CMP_W'(al_h) <= CMP_W'(al_size)) &&
                  (CMP_W'(r_cnt) <= CMP_W'(al_size) - CMP_W'(al_h));
        al_idx  = BIT_W'(ZB'(al_h)) + (pick ? BIT_W'(ZONE_PAGES) : '0);
    end

    // values for the commit of an allocation, zone already in r_zone
    logic [HINT_W-1:0] cm_h;
    logic [PFN_W-1:0]  cm_base;
    assign cm_h    = r_zone ? r_hint_b : r_hint_a;
    assign cm_base = r_zone ? r_b_base : r_a_base;

    logic [2*WORD_W-1:0] run_mask;
    logic                busy;
    assign run_mask = (((2*WORD_W)'(1) << r_cnt) - (2*WORD_W)'(1)) << r_off;
    assign rd_word  = r_rd_vld ? ram_rdata : '0;
    assign busy     = |({rd_word, r_word0} & run_mask);

    // ---------------- free lookup ----------------
    logic [PFN_W-1:0] off_a, off_b, f_offs;
    logic             hit_a, hit_b, f_zone;
    logic [BIT_W-1:0] f_idx;

    always_comb begin
        off_a  = r_cur - r_a_base;
        off_b  = r_cur - r_b_base;
        hit_a  = (r_cur >= r_a_base) && (off_a < PFN_W'(size_a));
        hit_b  = (ZONES > 1) && (r_cur >= r_b_base) && (off_b < PFN_W'(size_b));
        f_zone = !hit_a;
        f_offs = hit_a ? off_a : off_b;
        f_idx  = BIT_W'(ZB'(f_offs)) + (f_zone ? BIT_W'(ZONE_PAGES) : '0);
    end

    logic [CNT_W-1:0] fr_free, fr_size;
    assign fr_free = r_zone ? r_free_b : r_free_a;
    assign fr_size = r_zone ? size_b : size_a;

    // ---------------- bitmap port control ----------------
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_waddr;
        ram_wdata = r_word1;
        ram_raddr = r_waddr;
        case (r_state)
            S_ARD1: ram_raddr = r_waddr + WA_W'(1);
            S_FRD:  ram_raddr = f_idx[BIT_W-1:OFF_W];
            S_ACHK: begin
                ram_we    = !busy;
                ram_wdata = r_word0 | run_mask[WORD_W-1:0];
            end
            S_AWR1: begin
                // second word only when the run reaches into it
                ram_we    = |run_mask[2*WORD_W-1:WORD_W];
                ram_waddr = r_waddr + WA_W'(1);
            end
            S_FWR: begin
                ram_we    = 1'b1;
                ram_wdata = rd_word & ~(WORD_W'(1) << r_off);
            end
            default: ;
        endcase
    end

    zbpa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
            r_vld     <= '0;
            r_rd_vld  <= 1'b0;
            r_a_base  <= '0;
            r_b_base  <= '0;
            r_a_pages <= '0;
            r_b_pages <= '0;
            r_rsv     <= '0;
            r_free_a  <= '0;
            r_free_b  <= '0;
            r_hint_a  <= '0;
            r_hint_b  <= '0;
        end else begin
            r_rd_vld <= r_vld[ram_raddr];
            if (ram_we) begin
                r_vld[ram_waddr] <= 1'b1;
            end
            // in S_RESP the output register is reloaded below
            if (r_m_valid && m_axis_tready && r_state != S_RESP) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_func  <= s_axis_tuser[0];
                        r_pnum  <= s_axis_tdata[PFN_W-1:0];
                        r_cnt   <= s_axis_tdata[PFN_W+RUN_W-1:PFN_W];
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    if (int'(r_cnt) > MAX_RUN) begin
                        r_page   <= '0;
                        r_status <= ST_NOFIT;
                        r_state  <= S_RESP;
                    end else if (r_func == FN_FREE) begin
                        r_page   <= '0;
                        r_status <= ST_OK;
                        if (r_cnt != '0) begin
                            r_cur   <= r_pnum;
                            r_k     <= '0;
                            r_state <= S_FRD;
                        end else begin
                            r_state <= S_RESP;
                        end
                    end else if (!(a_ok || b_ok) || !al_fit) begin
                        r_page   <= '0;
                        r_status <= ST_NOFIT;
                        r_state  <= S_RESP;
                    end else if (r_cnt == '0) begin
                        // empty run: answer the hint page and step the hint by one
                        r_page   <= (pick ? r_b_base : r_a_base) + PFN_W'(al_h);
                        r_status <= ST_OK;
                        r_state  <= S_RESP;
                        if (pick) r_hint_b <= al_h + HINT_W'(1);
                        else      r_hint_a <= al_h + HINT_W'(1);
                    end else begin
                        r_page   <= '0;
                        r_status <= ST_OK;
                        r_zone   <= pick;
                        r_waddr  <= al_idx[BIT_W-1:OFF_W];
                        r_off    <= al_idx[OFF_W-1:0];
                        r_state  <= S_ARD0;
                    end
                end
                S_ARD0: r_state <= S_ARD1;
                S_ARD1: begin
                    r_word0 <= rd_word;
                    r_state <= S_ACHK;
                end
                S_ACHK: begin
                    if (busy) begin
                        r_status <= ST_NOFIT;
                        r_state  <= S_RESP;
                    end else begin
                        r_word1 <= rd_word | run_mask[2*WORD_W-1:WORD_W];
                        r_state <= S_AWR1;
                    end
                end
                S_AWR1: begin
                    r_page <= cm_base + PFN_W'(cm_h);
                    if (r_zone) begin
                        r_hint_b <= cm_h + HINT_W'(r_cnt) + HINT_W'(1);
                        r_free_b <= r_free_b - CNT_W'(r_cnt);
                    end else begin
                        r_hint_a <= cm_h + HINT_W'(r_cnt) + HINT_W'(1);
                        r_free_a <= r_free_a - CNT_W'(r_cnt);
                    end
                    r_state <= S_RESP;
                end
                S_FRD: begin
                    if (!(hit_a || hit_b)) begin
                        r_status <= ST_OUTSIDE;
                        r_state  <= S_RESP;
                    end else begin
                        r_zone  <= f_zone;
                        r_waddr <= f_idx[BIT_W-1:OFF_W];
                        r_off   <= f_idx[OFF_W-1:0];
                        r_state <= S_FWR;
                    end
                end
                S_FWR: begin
                    if (fr_free >= fr_size) begin
                        if (r_zone) r_free_b <= fr_size;
                        else        r_free_a <= fr_size;
                        r_status <= ST_OVERFLOW;
                        r_state  <= S_RESP;
                    end else begin
                        if (r_zone) r_free_b <= r_free_b + CNT_W'(1);
                        else        r_free_a <= r_free_a + CNT_W'(1);
                        r_k   <= r_k + RUN_W'(1);
                        r_cur <= r_cur + PFN_W'(1);
                        if (r_k + RUN_W'(1) == r_cnt) r_state <= S_RESP;
                        else                          r_state <= S_FRD;
                    end
                end
                S_RESP: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_valid  <= 1'b1;
                        r_m_page   <= (r_status == ST_OK) ? r_page : '0;
                        r_m_status <= r_status;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            // writes must arrive only while no request is in flight; the block does not enforce this
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_A_BASE:  r_a_base <= i_cfg_data[PFN_W-1:0];
                    CFG_A_PAGES: begin
                        r_a_pages <= i_cfg_data[CNT_W-1:0];
                        r_free_a  <= zone_size(i_cfg_data[CNT_W-1:0]);
                    end
                    CFG_B_BASE:  r_b_base <= i_cfg_data[PFN_W-1:0];
                    CFG_B_PAGES: begin
                        r_b_pages <= i_cfg_data[CNT_W-1:0];
                        r_free_b  <= zone_size(i_cfg_data[CNT_W-1:0]);
                    end
                    CFG_RSV:     r_rsv <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {2'b00, r_m_status, r_m_page};

endmodule
